[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/mnv_pkg.sv]
// Shared constants and types of the maximum-norm subset sum block.
// Used by the controller, the datapath and the top level.
package mnv_pkg;

   localparam int MAX_VECTORS_DEF = 1024;
   localparam int COORD_BITS_DEF  = 16;
   localparam int FIELD_BITS      = 16;
   localparam int OUT_BITS        = 52;
   localparam int OP_W            = 5;

   localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
   localparam logic [OP_W-1:0] OP_SPASS  = 5'd2;
   localparam logic [OP_W-1:0] OP_SPEND  = 5'd3;
   localparam logic [OP_W-1:0] OP_RUNI   = 5'd4;
   localparam logic [OP_W-1:0] OP_MMUL   = 5'd5;
   localparam logic [OP_W-1:0] OP_MSTEP  = 5'd6;
   localparam logic [OP_W-1:0] OP_RUNN   = 5'd7;
   localparam logic [OP_W-1:0] OP_DINIT  = 5'd8;
   localparam logic [OP_W-1:0] OP_DMUL   = 5'd9;
   localparam logic [OP_W-1:0] OP_DACC   = 5'd10;
   localparam logic [OP_W-1:0] OP_DFLUSH = 5'd11;
   localparam logic [OP_W-1:0] OP_PINIT  = 5'd12;
   localparam logic [OP_W-1:0] OP_PACC   = 5'd13;
   localparam logic [OP_W-1:0] OP_WINIT  = 5'd14;
   localparam logic [OP_W-1:0] OP_WMAX   = 5'd15;
   localparam logic [OP_W-1:0] OP_WMUL   = 5'd16;
   localparam logic [OP_W-1:0] OP_WBRK   = 5'd17;
   localparam logic [OP_W-1:0] OP_WSQ    = 5'd18;
   localparam logic [OP_W-1:0] OP_WBEST  = 5'd19;
   localparam logic [OP_W-1:0] OP_CLEAR  = 5'd20;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic pass_done;
      logic run_done;
      logic elem_done;
      logic scan_done;
      logic pfx_done;
      logic sweep_done;
      logic win_break;
   } status_type;

endpackage

[rtl/core/mnv_ctrl.sv]
// Sequencer of the maximum-norm subset sum block: load, sort, merge,
// prefix and window sweep phases. Depends on mnv_pkg.
module mnv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last,
   input  mnv_pkg::status_type status,
   output mnv_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_SPASS  = 5'd1;
   localparam logic [4:0] S_RUN    = 5'd2;
   localparam logic [4:0] S_MRD    = 5'd3;
   localparam logic [4:0] S_MMUL   = 5'd4;
   localparam logic [4:0] S_MSTEP  = 5'd5;
   localparam logic [4:0] S_MNEXT  = 5'd6;
   localparam logic [4:0] S_DINIT  = 5'd7;
   localparam logic [4:0] S_DRD    = 5'd8;
   localparam logic [4:0] S_DMUL   = 5'd9;
   localparam logic [4:0] S_DACC   = 5'd10;
   localparam logic [4:0] S_DFLUSH = 5'd11;
   localparam logic [4:0] S_PINIT  = 5'd12;
   localparam logic [4:0] S_PRD    = 5'd13;
   localparam logic [4:0] S_PACC   = 5'd14;
   localparam logic [4:0] S_WINIT  = 5'd15;
   localparam logic [4:0] S_WST    = 5'd16;
   localparam logic [4:0] S_WRD    = 5'd17;
   localparam logic [4:0] S_WMUL   = 5'd18;
   localparam logic [4:0] S_WCHK   = 5'd19;
   localparam logic [4:0] S_WBEST  = 5'd20;
   localparam logic [4:0] S_OUT    = 5'd21;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = mnv_pkg::OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = mnv_pkg::OP_LOAD;
               if (last) begin
                  state_in = S_SPASS;
               end
            end
         end
         S_SPASS: begin
            if (status.empty) begin
               state_in = S_OUT;
            end else if (status.pass_done) begin
               state_in = S_DINIT;
            end else begin
               cmd.op   = mnv_pkg::OP_SPASS;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (status.run_done) begin
               cmd.op   = mnv_pkg::OP_SPEND;
               state_in = S_SPASS;
            end else begin
               cmd.op   = mnv_pkg::OP_RUNI;
               state_in = S_MRD;
            end
         end
         S_MRD: state_in = S_MMUL;
         S_MMUL: begin
            cmd.op   = mnv_pkg::OP_MMUL;
            state_in = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.op   = mnv_pkg::OP_MSTEP;
            state_in = S_MNEXT;
         end
         S_MNEXT: begin
            if (status.elem_done) begin
               cmd.op   = mnv_pkg::OP_RUNN;
               state_in = S_RUN;
            end else begin
               state_in = S_MRD;
            end
         end
         S_DINIT: begin
            cmd.op   = mnv_pkg::OP_DINIT;
            state_in = S_DRD;
         end
         S_DRD: state_in = status.scan_done ? S_DFLUSH : S_DMUL;
         S_DMUL: begin
            cmd.op   = mnv_pkg::OP_DMUL;
            state_in = S_DACC;
         end
         S_DACC: begin
            cmd.op   = mnv_pkg::OP_DACC;
            state_in = S_DRD;
         end
         S_DFLUSH: begin
            cmd.op   = mnv_pkg::OP_DFLUSH;
            state_in = S_PINIT;
         end
         S_PINIT: begin
            cmd.op   = mnv_pkg::OP_PINIT;
            state_in = S_PRD;
         end
         S_PRD: state_in = status.pfx_done ? S_WINIT : S_PACC;
         S_PACC: begin
            cmd.op   = mnv_pkg::OP_PACC;
            state_in = S_PRD;
         end
         S_WINIT: begin
            cmd.op   = mnv_pkg::OP_WINIT;
            state_in = S_WST;
         end
         S_WST: begin
            if (status.sweep_done) begin
               state_in = S_OUT;
            end else begin
               cmd.op   = mnv_pkg::OP_WMAX;
               state_in = S_WRD;
            end
         end
         S_WRD: state_in = S_WMUL;
         S_WMUL: begin
            cmd.op   = mnv_pkg::OP_WMUL;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            if (status.win_break) begin
               cmd.op   = mnv_pkg::OP_WBRK;
               state_in = S_WST;
            end else begin
               cmd.op   = mnv_pkg::OP_WSQ;
               state_in = S_WBEST;
            end
         end
         S_WBEST: begin
            cmd.op   = mnv_pkg::OP_WBEST;
            state_in = S_WRD;
         end
         S_OUT: begin
            cmd.op   = mnv_pkg::OP_CLEAR;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

[rtl/core/mnv_dpath.sv]
// Datapath of the maximum-norm subset sum block: vector banks, merge sort,
// direction merge, prefix sums and window sweep. Depends on mnv_pkg.
module mnv_dpath #(
   parameter int MAX_VECTORS = mnv_pkg::MAX_VECTORS_DEF,
   parameter int COORD_BITS  = mnv_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mnv_pkg::cmd_type                      cmd,
   input  logic signed [mnv_pkg::FIELD_BITS-1:0] vec_x,
   input  logic signed [mnv_pkg::FIELD_BITS-1:0] vec_y,
   output mnv_pkg::status_type                   status,
   output logic [mnv_pkg::OUT_BITS-1:0]          max_sq_norm
);

   localparam int CW  = COORD_BITS;
   localparam int AW  = $clog2(MAX_VECTORS);
   localparam int NW  = AW + 1;
   localparam int LW  = AW + 3;
   localparam int EW  = AW + 2;
   localparam int PAW = AW + 1;
   localparam int SW  = CW + AW;
   localparam int PW  = SW + 1;
   localparam int VW  = 2 * CW;
   localparam int DW  = 2 * SW + 2 * CW;
   localparam int OB  = mnv_pkg::OUT_BITS;
   localparam int MB  = OB / 2;

   function automatic logic [2:0] dir_class(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      logic [2:0] c;
      if (x > 0) begin
         c = (y > 0) ? 3'd0 : ((y < 0) ? 3'd6 : 3'd7);
      end else if (x < 0) begin
         c = (y > 0) ? 3'd2 : ((y < 0) ? 3'd4 : 3'd3);
      end else begin
         c = (y > 0) ? 3'd1 : 3'd5;
      end
      return c;
   endfunction

   // Vector banks ping-pong between sort passes.
   logic [VW-1:0] bank_a [MAX_VECTORS];
   logic [VW-1:0] bank_b [MAX_VECTORS];
   logic [DW-1:0] dir_mem [MAX_VECTORS];
   logic [PW-1:0] pfx_x [2*MAX_VECTORS];
   logic [PW-1:0] pfx_y [2*MAX_VECTORS];

   logic [NW-1:0] n_ff, n_in, dcnt_ff, dcnt_in, s_ff, s_in;
   logic [LW-1:0] w_ff, w_in, lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [LW-1:0] p_ff, p_in, q_ff, q_in, k_ff, k_in;
   logic [EW-1:0] we_ff, we_in;
   logic          sel_ff, sel_in, cls_lt_ff, cls_lt_in, cls_eq_ff, cls_eq_in;
   logic          sat_ff, sat_in;
   logic signed [2*CW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic signed [SW-1:0]   accx_ff, accx_in, accy_ff, accy_in;
   logic signed [CW-1:0]   repx_ff, repx_in, repy_ff, repy_in;
   logic signed [PW-1:0]   pax_ff, pax_in, pay_ff, pay_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [2*MB-1:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [OB-1:0]          best_ff, best_in;

   logic [VW-1:0] a_p_ff, a_q_ff, b_p_ff, b_q_ff, src_p, src_q;
   logic [DW-1:0] dir_a_ff, dir_b_ff;
   logic [PW-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff;

   logic          a_we, b_we, d_we, p_we;
   logic [AW-1:0] a_addr, b_addr, d_addr;
   logic [PAW-1:0] p_addr;
   logic [VW-1:0] a_wdata, b_wdata;
   logic [DW-1:0] d_wdata;
   logic [PW-1:0] px_wdata, py_wdata;

   logic signed [CW-1:0] in_x, in_y, qx, qy, px, py;
   logic signed [CW-1:0] rsx, rsy, rex, rey;
   logic signed [SW-1:0] dsx, dsy;
   logic signed [CW-1:0] mul_a1, mul_a2, mul_b1, mul_b2;
   logic [EW-1:0] we_p1, e_full;
   logic          take_q;
   logic [PW-1:0] absx, absy;
   logic [MB-1:0] magx, magy;
   logic [OB:0]   sq_sum;
   logic [OB-1:0] nv;

   assign in_x  = CW'($unsigned(vec_x));
   assign in_y  = CW'($unsigned(vec_y));
   assign src_p = sel_ff ? b_p_ff : a_p_ff;
   assign src_q = sel_ff ? b_q_ff : a_q_ff;
   assign qx    = src_q[VW-1:CW];
   assign qy    = src_q[CW-1:0];
   assign px    = src_p[VW-1:CW];
   assign py    = src_p[CW-1:0];
   assign rsx   = dir_a_ff[2*CW-1:CW];
   assign rsy   = dir_a_ff[CW-1:0];
   assign rex   = dir_b_ff[2*CW-1:CW];
   assign rey   = dir_b_ff[CW-1:0];
   assign dsx   = dir_a_ff[DW-1 -: SW];
   assign dsy   = dir_a_ff[DW-SW-1 -: SW];
   assign we_p1 = we_ff + 1'b1;
   assign e_full = (we_ff < EW'(dcnt_ff)) ? we_ff : we_ff - EW'(dcnt_ff);
   assign take_q = (q_ff < hi_ff) &&
                   ((p_ff >= mid_ff) || cls_lt_ff || (cls_eq_ff && (prod_a_ff < prod_b_ff)));
   assign absx  = (dx_ff < 0) ? PW'(-dx_ff) : PW'(dx_ff);
   assign absy  = (dy_ff < 0) ? PW'(-dy_ff) : PW'(dy_ff);
   assign magx  = MB'(absx);
   assign magy  = MB'(absy);
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign nv    = (sat_ff || sq_sum[OB]) ? {OB{1'b1}} : sq_sum[OB-1:0];

   // One shared pair of multipliers serves the sort, merge and sweep phases.
   always_comb begin
      case (cmd.op)
         mnv_pkg::OP_MMUL: begin
            mul_a1 = qy;
            mul_a2 = px;
            mul_b1 = py;
            mul_b2 = qx;
         end
         mnv_pkg::OP_DMUL: begin
            mul_a1 = repx_ff;
            mul_a2 = py;
            mul_b1 = repy_ff;
            mul_b2 = px;
         end
         default: begin
            mul_a1 = rsx;
            mul_a2 = rey;
            mul_b1 = rsy;
            mul_b2 = rex;
         end
      endcase
   end

   always_comb begin
      n_in = n_ff;       dcnt_in = dcnt_ff;   s_in = s_ff;
      w_in = w_ff;       lo_in = lo_ff;       mid_in = mid_ff;   hi_in = hi_ff;
      p_in = p_ff;       q_in = q_ff;         k_in = k_ff;       we_in = we_ff;
      sel_in = sel_ff;   cls_lt_in = cls_lt_ff; cls_eq_in = cls_eq_ff;
      sat_in = sat_ff;   prod_a_in = prod_a_ff; prod_b_in = prod_b_ff;
      accx_in = accx_ff; accy_in = accy_ff;   repx_in = repx_ff; repy_in = repy_ff;
      pax_in = pax_ff;   pay_in = pay_ff;     dx_in = dx_ff;     dy_in = dy_ff;
      sqx_in = sqx_ff;   sqy_in = sqy_ff;     best_in = best_ff;
      a_we = 1'b0;       b_we = 1'b0;         d_we = 1'b0;       p_we = 1'b0;
      a_addr = n_ff[AW-1:0];
      b_addr = k_ff[AW-1:0];
      a_wdata = {in_x, in_y};
      b_wdata = take_q ? src_q : src_p;
      d_addr  = AW'(dcnt_ff - 1'b1);
      d_wdata = {accx_ff, accy_ff, repx_ff, repy_ff};
      p_addr  = we_p1[PAW-1:0];
      px_wdata = PW'(pax_ff + PW'(dsx));
      py_wdata = PW'(pay_ff + PW'(dsy));
      case (cmd.op)
         mnv_pkg::OP_LOAD: begin
            if (((in_x != 0) || (in_y != 0)) && (n_ff < NW'(MAX_VECTORS))) begin
               a_we = 1'b1;
               n_in = n_ff + 1'b1;
            end
         end
         mnv_pkg::OP_SPASS: lo_in = '0;
         mnv_pkg::OP_SPEND: begin
            w_in   = LW'(w_ff << 1);
            sel_in = ~sel_ff;
         end
         mnv_pkg::OP_RUNI: begin
            mid_in = (lo_ff + w_ff < LW'(n_ff)) ? lo_ff + w_ff : LW'(n_ff);
            hi_in  = (lo_ff + LW'(w_ff << 1) < LW'(n_ff)) ?
                     lo_ff + LW'(w_ff << 1) : LW'(n_ff);
            p_in   = lo_ff;
            q_in   = mid_in;
            k_in   = lo_ff;
         end
         mnv_pkg::OP_MMUL: begin
            prod_a_in = mul_a1 * mul_a2;
            prod_b_in = mul_b1 * mul_b2;
            cls_lt_in = dir_class(qx, qy) < dir_class(px, py);
            cls_eq_in = dir_class(qx, qy) == dir_class(px, py);
         end
         mnv_pkg::OP_MSTEP: begin
            if (sel_ff) begin
               a_we   = 1'b1;
               a_addr = k_ff[AW-1:0];
               a_wdata = b_wdata;
            end else begin
               b_we = 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (take_q) begin
               q_in = q_ff + 1'b1;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         mnv_pkg::OP_RUNN: lo_in = lo_ff + LW'(w_ff << 1);
         mnv_pkg::OP_DINIT: begin
            p_in    = '0;
            dcnt_in = '0;
         end
         mnv_pkg::OP_DMUL: begin
            prod_a_in = mul_a1 * mul_a2;
            prod_b_in = mul_b1 * mul_b2;
            cls_eq_in = dir_class(repx_ff, repy_ff) == dir_class(px, py);
         end
         mnv_pkg::OP_DACC: begin
            p_in = p_ff + 1'b1;
            if ((dcnt_ff != 0) && cls_eq_ff && (prod_a_ff == prod_b_ff)) begin
               accx_in = accx_ff + SW'(px);
               accy_in = accy_ff + SW'(py);
            end else begin
               // A new direction starts; the finished one goes to the store.
               d_we    = (dcnt_ff != 0);
               accx_in = SW'(px);
               accy_in = SW'(py);
               repx_in = px;
               repy_in = py;
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         mnv_pkg::OP_DFLUSH: d_we = 1'b1;
         mnv_pkg::OP_PINIT: begin
            we_in  = '0;
            s_in   = '0;
            pax_in = '0;
            pay_in = '0;
            p_we   = 1'b1;
            p_addr = '0;
            px_wdata = '0;
            py_wdata = '0;
         end
         mnv_pkg::OP_PACC: begin
            p_we   = 1'b1;
            pax_in = px_wdata;
            pay_in = py_wdata;
            we_in  = we_p1;
            s_in   = (s_ff == dcnt_ff - 1'b1) ? '0 : s_ff + 1'b1;
         end
         mnv_pkg::OP_WINIT: begin
            s_in  = '0;
            we_in = '0;
         end
         mnv_pkg::OP_WMAX: begin
            if (we_ff < EW'(s_ff)) begin
               we_in = EW'(s_ff);
            end
         end
         mnv_pkg::OP_WMUL: begin
            prod_a_in = mul_a1 * mul_a2;
            prod_b_in = mul_b1 * mul_b2;
            dx_in = PW'($signed(pxa_ff) - $signed(pxb_ff));
            dy_in = PW'($signed(pya_ff) - $signed(pyb_ff));
         end
         mnv_pkg::OP_WBRK: begin
            we_in = we_ff - 1'b1;
            s_in  = s_ff + 1'b1;
         end
         mnv_pkg::OP_WSQ: begin
            sqx_in = magx * magx;
            sqy_in = magy * magy;
            sat_in = ((absx >> MB) != '0) || ((absy >> MB) != '0);
            we_in  = we_p1;
         end
         mnv_pkg::OP_WBEST: begin
            if (nv > best_ff) begin
               best_in = nv;
            end
         end
         mnv_pkg::OP_CLEAR: begin
            n_in    = '0;
            w_in    = LW'(1);
            sel_in  = 1'b0;
            best_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         w_ff    <= LW'(1);
         sel_ff  <= 1'b0;
         best_ff <= '0;
      end else begin
         n_ff    <= n_in;
         w_ff    <= w_in;
         sel_ff  <= sel_in;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      dcnt_ff <= dcnt_in;   s_ff <= s_in;       lo_ff <= lo_in;
      mid_ff <= mid_in;     hi_ff <= hi_in;     p_ff <= p_in;
      q_ff <= q_in;         k_ff <= k_in;       we_ff <= we_in;
      cls_lt_ff <= cls_lt_in; cls_eq_ff <= cls_eq_in; sat_ff <= sat_in;
      prod_a_ff <= prod_a_in; prod_b_ff <= prod_b_in;
      accx_ff <= accx_in;   accy_ff <= accy_in; repx_ff <= repx_in; repy_ff <= repy_in;
      pax_ff <= pax_in;     pay_ff <= pay_in;   dx_ff <= dx_in;     dy_ff <= dy_in;
      sqx_ff <= sqx_in;     sqy_ff <= sqy_in;
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         bank_a[a_addr] <= a_wdata;
      end
      a_p_ff <= bank_a[p_ff[AW-1:0]];
      a_q_ff <= bank_a[q_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bank_b[b_addr] <= b_wdata;
      end
      b_p_ff <= bank_b[p_ff[AW-1:0]];
      b_q_ff <= bank_b[q_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dir_mem[d_addr] <= d_wdata;
      end
      dir_a_ff <= dir_mem[s_ff[AW-1:0]];
      dir_b_ff <= dir_mem[e_full[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         pfx_x[p_addr] <= px_wdata;
         pfx_y[p_addr] <= py_wdata;
      end
      pxa_ff <= pfx_x[we_p1[PAW-1:0]];
      pxb_ff <= pfx_x[PAW'(s_ff)];
      pya_ff <= pfx_y[we_p1[PAW-1:0]];
      pyb_ff <= pfx_y[PAW'(s_ff)];
   end

   assign status.empty      = (n_ff == '0);
   assign status.pass_done  = (w_ff >= LW'(n_ff));
   assign status.run_done   = (lo_ff >= LW'(n_ff));
   assign status.elem_done  = (p_ff >= mid_ff) && (q_ff >= hi_ff);
   assign status.scan_done  = (p_ff == LW'(n_ff));
   assign status.pfx_done   = (we_ff == EW'((EW'(dcnt_ff) << 1) - 1'b1));
   assign status.sweep_done = (s_ff == dcnt_ff);
   assign status.win_break  = (prod_a_ff < prod_b_ff) ||
                              (we_ff == EW'(s_ff) + EW'(dcnt_ff));
   assign max_sq_norm       = best_ff;

endmodule

[rtl/core/max_norm_vector_subset_sum.sv]
// Top level of the maximum-norm subset sum block.
// Depends on mnv_pkg, mnv_ctrl and mnv_dpath.
//
// Vectors are loaded one per cycle while busy is low. The word with req_last
// set closes the set; busy then stays high while the set is sorted (about
// ceil(log2 n) merge passes), merged into d directions, summed into prefixes
// (over 2d - 1 entries) and swept (at most 3d window steps). The result word
// appears on rsp_valid for exactly one cycle and must be taken then; busy
// falls on the next cycle. The run time after the last word is set by the
// single read port pair of each store and the shared multiplier pair that
// the sort, merge and sweep phases step through.
module max_norm_vector_subset_sum #(
   parameter int MAX_VECTORS = mnv_pkg::MAX_VECTORS_DEF,
   parameter int COORD_BITS  = mnv_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [mnv_pkg::FIELD_BITS-1:0] req_vec_x,
   input  logic signed [mnv_pkg::FIELD_BITS-1:0] req_vec_y,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   output logic [mnv_pkg::OUT_BITS-1:0]          rsp_max_sq_norm
);

   mnv_pkg::cmd_type    cmd;
   mnv_pkg::status_type status;

   mnv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last      (req_last),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mnv_dpath #(
      .MAX_VECTORS (MAX_VECTORS),
      .COORD_BITS  (COORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .vec_x       (req_vec_x),
      .vec_y       (req_vec_y),
      .status      (status),
      .max_sq_norm (rsp_max_sq_norm)
   );

endmodule

[rtl/core/mnv_checker.sv]
// Port-level checks of the maximum-norm subset sum block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mnv_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_valid
);

   `ASSERT_RST(a_rsp_while_busy, clock, reset, rsp_valid |-> busy)
   `ASSERT_RST(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid && !busy)
   `ASSERT_RST(a_last_goes_busy, clock, reset, (start && !busy && req_last) |=> busy && !rsp_valid)
   `ASSERT_RST(a_word_stays_idle, clock, reset, (start && !busy && !req_last) |=> !busy)
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid)

endmodule

bind max_norm_vector_subset_sum mnv_checker u_mnv_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_last  (req_last),
   .rsp_valid (rsp_valid)
);

[sim/tb_top.sv]
// Testbench for max_norm_vector_subset_sum: directed and random vector sets.
// The largest subset-sum norm is predicted here and each result word is checked.
// Depends on mnv_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

   localparam int FIELD_BITS  = mnv_pkg::FIELD_BITS;
   localparam int OUT_BITS    = mnv_pkg::OUT_BITS;
   localparam int STORE_DEPTH = mnv_pkg::MAX_VECTORS_DEF;
   localparam int IDLE_LIMIT  = 400000;
   localparam longint unsigned NORM_MASK = (64'd1 << OUT_BITS) - 1;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [FIELD_BITS-1:0] req_vec_x;
   logic signed [FIELD_BITS-1:0] req_vec_y;
   logic                         req_last;
   logic                         rsp_valid;
   logic [OUT_BITS-1:0]          rsp_max_sq_norm;

   longint set_x[$];
   longint set_y[$];
   longint unsigned norm_expected[$];
   int error_count;
   int words_sent;
   int idle_cycles;

   max_norm_vector_subset_sum u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_max_sq_norm(rsp_max_sq_norm)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int angle_class(input longint x, input longint y);
      if (x > 0) return (y > 0) ? 0 : ((y < 0) ? 6 : 7);
      if (x < 0) return (y > 0) ? 2 : ((y < 0) ? 4 : 3);
      return (y > 0) ? 1 : 5;
   endfunction

   function automatic bit turns_earlier(input longint ax, input longint ay,
                                        input longint bx, input longint by);
      int ca;
      int cb;
      ca = angle_class(ax, ay);
      cb = angle_class(bx, by);
      if (ca != cb) return ca < cb;
      return ay * bx < by * ax;
   endfunction

   function automatic longint unsigned square_sat(input longint a);
      longint unsigned m;
      m = (a < 0) ? -a : a;
      if (m >= (64'd1 << 26)) return NORM_MASK + 1;
      return m * m;
   endfunction

   function automatic longint unsigned norm_sat(input longint x, input longint y);
      longint unsigned s;
      s = square_sat(x) + square_sat(y);
      return (s > NORM_MASK) ? NORM_MASK : s;
   endfunction

   // Angular sweep over the merged directions of the collected set.
   function automatic longint unsigned best_subset_norm();
      int order[$];
      longint dx[$], dy[$], rx[$], ry[$];
      longint px[], py[];
      longint unsigned best;
      longint unsigned nv;
      longint cr;
      int n, sz, j, d, e, wend;
      best = 0;
      n = set_x.size();
      if (n == 0) return 0;
      for (int i = 0; i < n; i++) begin
         j = 0;
         while (j < order.size() &&
                !turns_earlier(set_x[i], set_y[i], set_x[order[j]], set_y[order[j]]))
            j++;
         order.insert(j, i);
      end
      foreach (order[i]) begin
         d = dx.size() - 1;
         if (d >= 0 && angle_class(rx[d], ry[d]) == angle_class(set_x[order[i]], set_y[order[i]])
             && rx[d] * set_y[order[i]] == ry[d] * set_x[order[i]]) begin
            dx[d] += set_x[order[i]];
            dy[d] += set_y[order[i]];
         end else begin
            dx.insert(dx.size(), set_x[order[i]]);
            dy.insert(dy.size(), set_y[order[i]]);
            rx.insert(rx.size(), set_x[order[i]]);
            ry.insert(ry.size(), set_y[order[i]]);
         end
      end
      sz = dx.size();
      px = new[2 * sz + 1];
      py = new[2 * sz + 1];
      px[0] = 0;
      py[0] = 0;
      for (int i = 0; i < 2 * sz; i++) begin
         px[i + 1] = px[i] + dx[i % sz];
         py[i + 1] = py[i] + dy[i % sz];
      end
      wend = 0;
      for (int s = 0; s < sz; s++) begin
         if (wend < s) wend = s;
         forever begin
            e = (wend < sz) ? wend : wend - sz;
            cr = rx[s] * ry[e] - ry[s] * rx[e];
            if (cr < 0 || wend == s + sz) break;
            nv = norm_sat(px[wend + 1] - px[s], py[wend + 1] - py[s]);
            if (nv > best) best = nv;
            wend++;
         end
         wend--;
      end
      return best;
   endfunction

   // Sends one word; the set is updated only when the word is taken.
   task automatic send_vector(input logic signed [FIELD_BITS-1:0] x,
                              input logic signed [FIELD_BITS-1:0] y,
                              input logic last, input int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_last  <= last;
      do @(posedge clock); while (busy);
      words_sent++;
      if ((x != 0 || y != 0) && set_x.size() < STORE_DEPTH) begin
         set_x.insert(set_x.size(), longint'(x));
         set_y.insert(set_y.size(), longint'(y));
      end
      if (last) begin
         norm_expected.insert(norm_expected.size(), best_subset_norm());
         set_x.delete();
         set_y.delete();
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (norm_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_set();
      wait_drained();
      send_vector(16'sd0, 16'sd0, 1'b1, 0);
      send_vector(16'sd0, 16'sd0, 1'b0, 2);
      send_vector(16'sd0, 16'sd0, 1'b1, 0);
      send_vector(16'sd9, -16'sd4, 1'b1, 0);
   endtask

   task automatic test_extremes();
      wait_drained();
      send_vector(-16'sd32768, -16'sd32768, 1'b0, 0);
      send_vector(16'sd32767, 16'sd32767, 1'b1, 0);
      send_vector(16'sd32767, -16'sd32768, 1'b0, 1);
      send_vector(-16'sd32768, 16'sd32767, 1'b0, 0);
      send_vector(16'sd0, 16'sd0, 1'b1, 3);
      send_vector(-16'sd32768, -16'sd32768, 1'b0, 0);
      send_vector(-16'sd32768, -16'sd32768, 1'b1, 0);
   endtask

   task automatic test_axes_and_merge();
      wait_drained();
      send_vector(16'sd5, 16'sd0, 1'b0, 0);
      send_vector(16'sd0, 16'sd5, 1'b0, 0);
      send_vector(-16'sd5, 16'sd0, 1'b0, 0);
      send_vector(16'sd0, -16'sd5, 1'b0, 0);
      send_vector(16'sd3, 16'sd0, 1'b1, 0);
      send_vector(16'sd2, 16'sd4, 1'b0, 0);
      send_vector(16'sd1, 16'sd2, 1'b0, 0);
      send_vector(-16'sd1, -16'sd2, 1'b0, 0);
      send_vector(16'sd3, 16'sd1, 1'b1, 0);
      send_vector(16'sd7, 16'sd7, 1'b0, 0);
      send_vector(-16'sd7, -16'sd7, 1'b1, 0);
   endtask

   // More nonzero words than the store holds; the closing word is dropped
   // but still ends the set.
   task automatic test_store_full();
      wait_drained();
      for (int i = 0; i < STORE_DEPTH + 6; i++)
         send_vector(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                     i == STORE_DEPTH + 5, 0);
   endtask

   task automatic test_random_sets();
      int size;
      bit narrow;
      bit gappy;
      logic signed [FIELD_BITS-1:0] x, y;
      while (words_sent < 1650) begin
         if ($urandom_range(0, 19) == 0) wait_drained();
         size   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         narrow = $urandom_range(0, 1);
         gappy  = $urandom_range(0, 1);
         for (int i = 0; i < size; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               x = 0;
               y = 0;
            end else if (narrow) begin
               x = FIELD_BITS'($signed($urandom_range(0, 6)) - 3);
               y = FIELD_BITS'($signed($urandom_range(0, 6)) - 3);
            end else begin
               x = 16'($urandom_range(0, 65535));
               y = 16'($urandom_range(0, 65535));
            end
            send_vector(x, y, i == size - 1, gappy ? $urandom_range(0, 15) : 0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (norm_expected.size() == 0)
            report($sformatf("unexpected result %0d", rsp_max_sq_norm));
         else begin
            if (rsp_max_sq_norm !== norm_expected[0])
               report($sformatf("max_sq_norm got %0d expected %0d",
                                rsp_max_sq_norm, norm_expected[0]));
            void'(norm_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_vec_x   = '0;
      req_vec_y   = '0;
      req_last    = 1'b0;
      error_count = 0;
      words_sent  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_set();
      test_extremes();
      test_axes_and_merge();
      test_store_full();
      test_random_sets();
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mnv_pkg.sv
rtl/core/mnv_ctrl.sv
rtl/core/mnv_dpath.sv
rtl/core/max_norm_vector_subset_sum.sv
rtl/core/mnv_checker.sv
sim/tb_top.sv
